// ----- src/compressed_block_texture_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// compressed block texture decoder assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef COMPRESSED_BLOCK_TEXTURE_DECODER_DEFINES_SVH
`define COMPRESSED_BLOCK_TEXTURE_DECODER_DEFINES_SVH

// same-cycle implication, held off during reset
`define CBTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CBTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also spans reset
`define CBTD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cbtd_pkg.sv -----
// ---------------------------------------------------------------------------
// cbtd_pkg
// types, constants and helpers of the compressed block texture decoder
// ---------------------------------------------------------------------------
package cbtd_pkg;

  localparam int MAX_DIMENSION = 1024;
  localparam int DIM_W         = 11;
  localparam int COORD_W       = 10;
  localparam int TILE_W        = 7;
  localparam int COLS_W        = TILE_W + 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  // reciprocal of three, scaled by 2^11, exact for sums below 2048
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  // register indexes, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [31:0] index_bits;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               last;
  } texel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // one classified sub-block on its way to the texel sequencer
  typedef struct packed {
    rgba_t [3:0]        pal;
    logic [31:0]        index_bits;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [15:0]        mask;
  } entry_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) res = DIM_W'(MAX_DIMENSION);
    return res;
  endfunction

  function automatic logic [23:0] widen565(input logic [15:0] c);
    return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] prod;
    prod = 20'(v) * 20'(RECIP3);
    return prod[RECIP3_SHIFT +: 8];
  endfunction

endpackage

// ----- src/cbtd_front.sv -----
// ---------------------------------------------------------------------------
// cbtd_front
// accepts sub-blocks, tracks tile position, builds palette and texel mask
// ---------------------------------------------------------------------------
module cbtd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  cbtd_pkg::item_t           item,
  input  logic [cbtd_pkg::DIM_W-1:0] image_width,
  input  logic [cbtd_pkg::DIM_W-1:0] image_height,
  input  logic                      q_full,
  output logic                      q_push,
  output cbtd_pkg::entry_t          q_data
);
  import cbtd_pkg::*;

  logic [TILE_W-1:0] tile_column;
  logic [TILE_W-1:0] tile_row;
  logic [1:0]        sub_block;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [COLS_W-1:0]  cols;
  logic [COLS_W-1:0]  rows;
  logic [DIM_W:0]     w_round;
  logic [DIM_W:0]     h_round;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] y0;
  logic [3:0]         col_ok;
  logic [3:0]         row_ok;
  logic [15:0]        mask;
  logic [23:0]        ea;
  logic [23:0]        eb;
  logic               a_gt_b;
  logic               accept;
  rgba_t [3:0]        pal;

  assign w_eff   = eff_dim(image_width);
  assign h_eff   = eff_dim(image_height);
  assign w_round = {1'b0, w_eff} + (DIM_W+1)'(7);
  assign h_round = {1'b0, h_eff} + (DIM_W+1)'(7);
  assign cols    = w_round[3 +: COLS_W];
  assign rows    = h_round[3 +: COLS_W];

  assign x0 = {tile_column, sub_block[0], 2'b00};
  assign y0 = {tile_row, sub_block[1], 2'b00};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_ok[i] = ({1'b0, x0} + DIM_W'(i)) < w_eff;
      row_ok[i] = ({1'b0, y0} + DIM_W'(i)) < h_eff;
    end
    for (int k = 0; k < 16; k++) begin
      mask[k] = row_ok[k / 4] & col_ok[k % 4];
    end
  end

  // palette: two endpoints and two blends, per channel, truncated
  assign ea     = widen565(item.color_a);
  assign eb     = widen565(item.color_b);
  assign a_gt_b = item.color_a > item.color_b;

  always_comb begin
    logic [9:0] a2b;
    logic [9:0] ab2;
    logic [8:0] ab;
    pal[0] = {ea, 8'hff};
    pal[1] = {eb, 8'hff};
    pal[2].a = 8'hff;
    pal[3].a = a_gt_b ? 8'hff : 8'h00;
    for (int ch = 0; ch < 3; ch++) begin
      a2b = {1'b0, ea[8*ch +: 8], 1'b0} + 10'(eb[8*ch +: 8]);
      ab2 = 10'(ea[8*ch +: 8]) + {1'b0, eb[8*ch +: 8], 1'b0};
      ab  = 9'(ea[8*ch +: 8]) + 9'(eb[8*ch +: 8]);
      // channel 2 is red, 1 green, 0 blue in the packed colour
      case (ch)
        2: begin
          pal[2].r = a_gt_b ? div3(a2b) : ab[8:1];
          pal[3].r = div3(ab2);
        end
        1: begin
          pal[2].g = a_gt_b ? div3(a2b) : ab[8:1];
          pal[3].g = div3(ab2);
        end
        default: begin
          pal[2].b = a_gt_b ? div3(a2b) : ab[8:1];
          pal[3].b = div3(ab2);
        end
      endcase
    end
  end

  assign accept = push && !q_full;
  assign q_push = accept && (mask != '0);

  always_comb begin
    q_data.pal        = pal;
    q_data.index_bits = item.index_bits;
    q_data.x0         = x0;
    q_data.y0         = y0;
    q_data.mask       = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column <= '0;
      tile_row    <= '0;
      sub_block   <= '0;
    end else if (accept) begin
      if (sub_block != 2'd3) begin
        sub_block <= sub_block + 2'd1;
      end else begin
        sub_block <= '0;
        if (({1'b0, tile_column} + COLS_W'(1)) >= cols) begin
          tile_column <= '0;
          if (({1'b0, tile_row} + COLS_W'(1)) >= rows) tile_row <= '0;
          else tile_row <= tile_row + TILE_W'(1);
        end else begin
          tile_column <= tile_column + TILE_W'(1);
        end
      end
    end
  end

endmodule

// ----- src/cbtd_queue.sv -----
// ---------------------------------------------------------------------------
// cbtd_queue
// short queue of classified sub-blocks between front and back
// ---------------------------------------------------------------------------
module cbtd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  cbtd_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output cbtd_pkg::entry_t rd_data,
  output logic             empty
);
  import cbtd_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ----- src/cbtd_back.sv -----
// ---------------------------------------------------------------------------
// cbtd_back
// texel sequencer: while the queue holds work and pop keeps pace, one texel of the current sub-block per cycle
// ---------------------------------------------------------------------------
module cbtd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cbtd_pkg::entry_t  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output cbtd_pkg::texel_t  texel
);
  import cbtd_pkg::*;

  entry_t      cur;
  logic [15:0] rem;
  logic        active;
  logic        out_valid;
  texel_t      texel_r;

  logic [3:0]  k;
  logic [15:0] pick;
  logic [15:0] rem_after;
  logic        out_ready;
  logic        emit;
  logic        finish;
  logic        load;
  logic [4:0]  shamt;
  logic [31:0] sel_word;
  logic [1:0]  sel;
  rgba_t       colour;
  texel_t      texel_next;

  // lowest raster index still pending
  always_comb begin
    k = '0;
    for (int i = 15; i >= 0; i--) begin
      if (rem[i]) k = 4'(i);
    end
  end

  assign pick      = 16'd1 << k;
  assign rem_after = rem & ~pick;
  assign out_ready = !out_valid || pop;
  assign emit      = active && out_ready;
  assign finish    = emit && (rem_after == '0);
  assign load      = !q_empty && (!active || finish);
  assign q_pop     = load;

  assign shamt    = 5'd30 - {k, 1'b0};
  assign sel_word = cur.index_bits >> shamt;
  assign sel      = sel_word[1:0];
  assign colour   = cur.pal[sel];

  always_comb begin
    texel_next.texel_x = cur.x0 + COORD_W'(k[1:0]);
    texel_next.texel_y = cur.y0 + COORD_W'(k[3:2]);
    texel_next.red     = colour.r;
    texel_next.green   = colour.g;
    texel_next.blue    = colour.b;
    texel_next.alpha   = colour.a;
    texel_next.last    = rem_after == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      rem       <= '0;
    end else begin
      if (load) begin
        active <= 1'b1;
        rem    <= q_data.mask;
      end else if (finish) begin
        active <= 1'b0;
        rem    <= '0;
      end else if (emit) begin
        rem <= rem_after;
      end
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= q_data;
    if (emit) texel_r <= texel_next;
  end

  assign empty = !out_valid;
  assign texel = texel_r;

endmodule

// ----- src/compressed_block_texture_decoder.sv -----
// ---------------------------------------------------------------------------
// compressed_block_texture_decoder
// 4x4 colour-endpoint sub-block decoder with image position tracking
// ---------------------------------------------------------------------------
// Each pushed transaction is one 4x4 sub-block (two RGB565 endpoints and
// sixteen 2-bit selectors); the block decodes it into up to sixteen texels,
// popped one transaction per texel in raster order with image coordinates,
// and marks the final texel of the sub-block with last. Sub-blocks are
// expected in 8x8 tiles of 2x2 sub-blocks, tiles left to right then top to
// bottom; texels at or beyond image_width or image_height are dropped, and a
// sub-block wholly outside the image gives no texels but still advances the
// position. The output side delivers one texel per clock while the queue
// holds work and pop keeps pace; a sub-block wholly outside never enters the
// queue. The front end classifies a sub-block in the cycle it is accepted
// and hands it to a two-entry queue, so push flows while the sequencer is
// busy until the queue fills; between push and its first texel lie the
// queue slot, the sequencer's current entry and the texel output register.
// Registers (APB, 32-bit data): image_width at 0x0, image_height at 0x4,
// 11 bits each, reset 8; zero acts as 1 and values above 1024 as 1024.
// Rewrite them only when the block is idle.
// ---------------------------------------------------------------------------
module compressed_block_texture_decoder (
  input  logic                         clk,
  input  logic                         rst,
  // sub-block input
  input  logic                         push,
  output logic                         full,
  input  cbtd_pkg::item_t              item,
  // texel output
  output logic                         empty,
  input  logic                         pop,
  output cbtd_pkg::texel_t             texel,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbtd_pkg::PADDR_W-1:0] paddr,
  input  logic [cbtd_pkg::PDATA_W-1:0] pwdata,
  output logic [cbtd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import cbtd_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             reg_sel;
  logic             cfg_write;

  // front to queue
  logic             f_push;
  entry_t           f_data;
  logic             q_full;
  // queue to sequencer
  logic             q_pop;
  entry_t           q_data;
  logic             q_empty;

  // --- configuration port: zero wait states, word-aligned registers
  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(8);
      image_height <= DIM_W'(8);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // --- front end: position tracking, palette and clip mask
  cbtd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .item         (item),
    .image_width  (image_width),
    .image_height (image_height),
    .q_full       (q_full),
    .q_push       (f_push),
    .q_data       (f_data)
  );

  // input stalls only when the decoupling queue is full
  assign full = q_full;

  // --- decoupling queue
  cbtd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // --- back end: texel sequencer with registered output
  cbtd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .texel   (texel)
  );

endmodule

// ----- src/cbtd_checker.sv -----
// ---------------------------------------------------------------------------
// cbtd_checker
// port-level checks of the texel output, bound to the top level
// ---------------------------------------------------------------------------
`include "compressed_block_texture_decoder_defines.svh"

module cbtd_checker (
  input logic             clk,
  input logic             rst,
  input logic             pop,
  input logic             empty,
  input cbtd_pkg::texel_t texel
);
  import cbtd_pkg::*;

  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic               in_order;
  logic               taken;
  logic               alpha_ok;

  assign taken    = pop && !empty && !texel.last;
  assign alpha_ok = (texel.alpha == 8'h00) || (texel.alpha == 8'hff);
  assign in_order = (texel.texel_y > prev_y) ||
                    ((texel.texel_y == prev_y) && (texel.texel_x > prev_x));

  always_ff @(posedge clk) begin
    if (pop && !empty) begin
      prev_x <= texel.texel_x;
      prev_y <= texel.texel_y;
    end
  end

  `CBTD_ASSERT_NEXT_ALWAYS(empty_after_reset, clk, rst, empty, "texel shown right after reset")
  `CBTD_ASSERT_NEXT(raster_order, clk, rst, taken, empty || in_order, "texel out of raster order")
  `CBTD_ASSERT_SAME(alpha_values, clk, rst, !empty, alpha_ok, "alpha neither opaque nor clear")
  `CBTD_ASSERT_NEXT(hold_stalled, clk, rst, !empty && !pop, !empty && $stable(texel), "texel moved")

endmodule

bind compressed_block_texture_decoder cbtd_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .pop   (pop),
  .empty (empty),
  .texel (texel)
);
